>>> hdl/bpsm_pkg.sv
// Package: request/response types, command codes and control/status bundles.
package bpsm_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_ALLOCATE = 3'd1;
    localparam logic [2:0] CMD_RELEASE  = 3'd2;
    localparam logic [2:0] CMD_SET      = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;
    localparam logic [2:0] CMD_FIND     = 3'd5;
    localparam logic [2:0] CMD_CLEAR    = 3'd6;

    localparam logic [31:0] BUSY_MARK = 32'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  slot_id;
        logic [31:0] handle;
        logic [31:0] mask;
    } t_req;

    typedef struct packed {
        logic        result_code;
        logic [7:0]  found_slot;
        logic [31:0] slot_handle;
        logic [31:0] slot_status;
        logic        free_available;
        logic [7:0]  active_total;
    } t_rsp;

    typedef enum logic [1:0] {
        SU_ALLOC = 2'd0,
        SU_FIND  = 2'd1,
        SU_FREE  = 2'd2
    } t_scan_use;

    typedef struct packed {
        logic      accept;
        logic      clear_status;
        logic      rd_slot;
        logic      exec;
        logic      scan_init;
        logic      scan_run;
        t_scan_use scan_use;
    } t_ctl;

    typedef struct packed {
        logic scan_hit;
        logic scan_done;
    } t_sts;

endpackage

>>> hdl/bpsm_datapath.sv
// Datapath: slot memories, valid bits, active count, slot scanner and result registers.
module bpsm_datapath #(
    parameter int NUM_SLOTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpsm_pkg::t_req i_req,
    input  bpsm_pkg::t_ctl i_ctl,
    output bpsm_pkg::t_sts o_sts,
    output bpsm_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    bpsm_pkg::t_req r_req;

    logic [31:0] r_handle_mem [NUM_SLOTS];
    logic [31:0] r_status_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_hvld;
    logic [NUM_SLOTS-1:0] r_svld;

    logic [31:0] r_rd_hmem;
    logic [31:0] r_rd_smem;
    logic        r_rd_hv;
    logic        r_rd_sv;

    logic [7:0]    r_active;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_lim;
    logic          r_pend;
    logic [AW-1:0] r_pidx;

    logic        r_code;
    logic [7:0]  r_fslot;
    logic [31:0] r_shandle;
    logic [31:0] r_sstatus;
    logic        r_free;

    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_h;
    logic [31:0]   rd_s;
    logic          slot_free;
    logic          scan_match;
    logic          hit;
    logic          issue;
    logic          done;
    logic [CW-1:0] n_lim;
    logic          id_ok;
    logic          id_act;
    logic [AW-1:0] id_idx;

    logic        ex_ok;
    logic        ex_hwe;
    logic        ex_swe;
    logic        ex_inc;
    logic [31:0] ex_sdata;
    logic [31:0] ex_shandle;
    logic [31:0] ex_sstatus;
    logic [31:0] rel_s;
    logic [31:0] rel_fix;
    logic [31:0] set_s;

    logic          h_we;
    logic          s_we;
    logic [AW-1:0] s_wa;
    logic [31:0]   s_wd;
    logic          alloc_hit;

    assign rd_addr    = i_ctl.rd_slot ? r_req.slot_id[AW-1:0] : r_addr[AW-1:0];
    assign rd_h       = r_rd_hv ? r_rd_hmem : 32'd0;
    assign rd_s       = r_rd_sv ? r_rd_smem : 32'd0;
    assign slot_free  = (rd_s == 32'd0) && (rd_h != 32'd0);
    assign scan_match = (i_ctl.scan_use == bpsm_pkg::SU_FIND) ? (rd_h == r_req.handle)
                                                              : slot_free;
    assign hit        = i_ctl.scan_run && r_pend && scan_match;
    assign issue      = i_ctl.scan_run && (r_addr < r_lim);
    assign done       = hit || (!r_pend && (r_addr >= r_lim));
    assign n_lim      = (r_active < 8'(NUM_SLOTS)) ? CW'(r_active) : CW'(NUM_SLOTS);

    assign id_ok  = r_req.slot_id < 8'(NUM_SLOTS);
    assign id_act = id_ok && (r_req.slot_id < r_active);
    assign id_idx = r_req.slot_id[AW-1:0];

    assign rel_s   = rd_s & ~r_req.mask;
    assign rel_fix = (rel_s == bpsm_pkg::BUSY_MARK) ? 32'd0 : rel_s;
    assign set_s   = rd_s | r_req.mask;

    always_comb begin
        ex_ok      = 1'b0;
        ex_hwe     = 1'b0;
        ex_swe     = 1'b0;
        ex_inc     = 1'b0;
        ex_sdata   = 32'd0;
        ex_shandle = 32'd0;
        ex_sstatus = 32'd0;
        unique case (r_req.command)
            bpsm_pkg::CMD_ADD: begin
                ex_ok  = id_ok && ((rd_h == 32'd0) || (rd_h == r_req.handle));
                ex_hwe = ex_ok;
                ex_inc = ex_ok;
            end
            bpsm_pkg::CMD_RELEASE: begin
                ex_ok      = id_act;
                ex_swe     = ex_ok;
                ex_sdata   = rel_fix;
                ex_sstatus = ex_ok ? rel_fix : 32'd0;
            end
            bpsm_pkg::CMD_SET: begin
                ex_ok      = id_act && ((rd_s & r_req.mask) == 32'd0);
                ex_swe     = ex_ok;
                ex_sdata   = set_s;
                ex_sstatus = ex_ok ? set_s : 32'd0;
            end
            bpsm_pkg::CMD_QUERY: begin
                ex_ok      = id_ok;
                ex_shandle = ex_ok ? rd_h : 32'd0;
                ex_sstatus = ex_ok ? rd_s : 32'd0;
            end
            default: begin
                ex_ok = 1'b0;
            end
        endcase
    end

    assign alloc_hit = hit && (i_ctl.scan_use == bpsm_pkg::SU_ALLOC);
    assign h_we      = i_ctl.exec && ex_hwe;
    assign s_we      = (i_ctl.exec && ex_swe) || alloc_hit;
    assign s_wa      = i_ctl.exec ? id_idx : r_pidx;
    assign s_wd      = i_ctl.exec ? ex_sdata : bpsm_pkg::BUSY_MARK;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_handle_mem[id_idx] <= r_req.handle;
        end
        if (s_we) begin
            r_status_mem[s_wa] <= s_wd;
        end
        r_rd_hmem <= r_handle_mem[rd_addr];
        r_rd_smem <= r_status_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld   <= '0;
            r_svld   <= '0;
            r_active <= 8'd0;
            r_pend   <= 1'b0;
        end else begin
            if (h_we) begin
                r_hvld[id_idx] <= 1'b1;
            end
            if (i_ctl.clear_status) begin
                r_svld <= '0;
            end else if (s_we) begin
                r_svld[s_wa] <= 1'b1;
            end
            if (i_ctl.exec && ex_inc && (r_active != 8'hFF)) begin
                r_active <= r_active + 8'd1;
            end
            if (i_ctl.scan_init) begin
                r_pend <= 1'b0;
            end else if (i_ctl.scan_run) begin
                r_pend <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_req <= i_req;
        end
        r_rd_hv <= r_hvld[rd_addr];
        r_rd_sv <= r_svld[rd_addr];
        if (i_ctl.scan_init) begin
            r_addr <= '0;
            r_lim  <= n_lim;
        end else if (issue) begin
            r_addr <= r_addr + CW'(1);
        end
        if (issue) begin
            r_pidx <= r_addr[AW-1:0];
        end

        if (i_ctl.accept) begin
            r_code    <= 1'b1;
            r_fslot   <= 8'd0;
            r_shandle <= 32'd0;
            r_sstatus <= 32'd0;
        end
        if (i_ctl.clear_status) begin
            r_code <= 1'b0;
        end
        if (i_ctl.exec) begin
            r_code    <= !ex_ok;
            r_shandle <= ex_shandle;
            r_sstatus <= ex_sstatus;
        end
        if (hit) begin
            unique case (i_ctl.scan_use)
                bpsm_pkg::SU_ALLOC: begin
                    r_code    <= 1'b0;
                    r_fslot   <= 8'(r_pidx);
                    r_shandle <= rd_h;
                end
                bpsm_pkg::SU_FIND: begin
                    r_code  <= 1'b0;
                    r_fslot <= 8'(r_pidx);
                end
                default: begin
                    r_code <= r_code;
                end
            endcase
        end
        if (i_ctl.scan_run && (i_ctl.scan_use == bpsm_pkg::SU_FREE) && done) begin
            r_free <= hit;
        end
    end

    assign o_sts.scan_hit  = hit;
    assign o_sts.scan_done = done;

    assign o_rsp.result_code    = r_code;
    assign o_rsp.found_slot     = r_fslot;
    assign o_rsp.slot_handle    = r_shandle;
    assign o_rsp.slot_status    = r_sstatus;
    assign o_rsp.free_available = r_free;
    assign o_rsp.active_total   = r_active;

endmodule

>>> hdl/bpsm_ctrl.sv
// Controller: state machine sequencing slot access, scans and result strobe.
module bpsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_cmd,
    input  bpsm_pkg::t_sts i_sts,
    output bpsm_pkg::t_ctl o_ctl,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_ASCAN = 8'b0000_1000,
        S_HSCAN = 8'b0001_0000,
        S_FINIT = 8'b0010_0000,
        S_FSCAN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.scan_use = bpsm_pkg::SU_FREE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.accept = 1'b1;
                    priority if ((i_cmd == bpsm_pkg::CMD_ADD) ||
                                 (i_cmd == bpsm_pkg::CMD_RELEASE) ||
                                 (i_cmd == bpsm_pkg::CMD_SET) ||
                                 (i_cmd == bpsm_pkg::CMD_QUERY)) begin
                        n_state = S_READ;
                    end else if (i_cmd == bpsm_pkg::CMD_ALLOCATE) begin
                        o_ctl.scan_init = 1'b1;
                        n_state = S_ASCAN;
                    end else if (i_cmd == bpsm_pkg::CMD_FIND) begin
                        o_ctl.scan_init = 1'b1;
                        n_state = S_HSCAN;
                    end else if (i_cmd == bpsm_pkg::CMD_CLEAR) begin
                        o_ctl.clear_status = 1'b1;
                        n_state = S_FINIT;
                    end else begin
                        n_state = S_FINIT;
                    end
                end
            end
            S_READ: begin
                o_ctl.rd_slot = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state = S_FINIT;
            end
            S_ASCAN: begin
                o_ctl.scan_run = 1'b1;
                o_ctl.scan_use = bpsm_pkg::SU_ALLOC;
                if (i_sts.scan_done) begin
                    n_state = S_FINIT;
                end
            end
            S_HSCAN: begin
                o_ctl.scan_run = 1'b1;
                o_ctl.scan_use = bpsm_pkg::SU_FIND;
                if (i_sts.scan_done) begin
                    n_state = S_FINIT;
                end
            end
            S_FINIT: begin
                o_ctl.scan_init = 1'b1;
                n_state = S_FSCAN;
            end
            S_FSCAN: begin
                o_ctl.scan_run = 1'b1;
                o_ctl.scan_use = bpsm_pkg::SU_FREE;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

>>> hdl/buffer_pool_status_manager.sv
// Top level: buffer pool slot table with status words and active count.
// Usage:
//   A request (command, slot id, handle, mask on i_req) is taken at a rising
//   edge where start is high and busy is low. busy stays high until the
//   response has been shown. The response on o_rsp is marked by o_done, high for exactly one
//   cycle; the receiver cannot stall it and must take it.
//   Add, release, set status and query read the addressed slot, then execute;
//   allocate and find first walk the slot memories for a match; clear status
//   and unused codes do neither. Every request then closes with a free-slot
//   check. The single-read-port slot memories are walked one slot per cycle,
//   over min(active count, NUM_SLOTS) slots, for the search and for the
//   free-slot check. A new request is taken the cycle after o_done.
//   Reset clears the active count and the per-slot valid bits, so every slot
//   reads as empty with zero status; there is no clearing pass.
module buffer_pool_status_manager #(
    parameter int NUM_SLOTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bpsm_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output bpsm_pkg::t_rsp o_rsp
);

    bpsm_pkg::t_ctl ctl;
    bpsm_pkg::t_sts sts;

    bpsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_req.command),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bpsm_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("response strobe longer than one cycle");

    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a response");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.found_slot < 8'(NUM_SLOTS)))
        else $error("found slot out of range");
`endif

endmodule
